// File: design/lst_pkg.sv
// Shared types, constants and helpers of the LIN schedule table.
// Used by lst_ctrl, lst_dp and the top level lin_schedule_table.
package lst_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [3:0] MAX_SIZE = 4'd8;

  typedef enum logic [2:0] {
    MODE_SET_REQ  = 3'd0,
    MODE_SET_RECV = 3'd1,
    MODE_REMOVE   = 3'd2,
    MODE_TICK     = 3'd3,
    MODE_FRAME    = 3'd4,
    MODE_QUERY    = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ACT_DONE      = 3'd0,
    ACT_SEND_REQ  = 3'd1,
    ACT_RECV_RESP = 3'd2,
    ACT_NO_SLOTS  = 3'd3,
    ACT_UNREG_ID  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  id;
    logic [3:0]  data_size;
    logic [63:0] data_bytes;
    logic        frame_error;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  out_id;
    logic [3:0]  out_size;
    logic [63:0] out_data;
    logic        is_receiver;
    logic        data_valid;
    logic        found;
  } out_item_t;

  // Slot contents apart from the identifier.
  typedef struct packed {
    logic [3:0]  size;
    logic [63:0] data;
    logic        rx;
    logic        valid;
  } slot_pl_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_step;
    logic exec;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [3:0] clamp_size(input logic [3:0] s);
    return (s > MAX_SIZE) ? MAX_SIZE : s;
  endfunction

endpackage

// File: design/lst_ctrl.sv
// Sequencer of the LIN schedule table: accept, table scan, execute.
// Depends on lst_pkg; drives the command struct of lst_dp.
module lst_ctrl import lst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // An item is only taken while nothing else is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_SCAN && in_stall_o)
    else $error("load did not start a scan");

  // The result is only produced after a completed scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> $past(status_i.scan_last) || $past(state_q == ST_EXEC))
    else $error("execute without a completed scan");

  // No command leaves the controller while idle without an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !in_valid_i) |-> cmd_o == '0)
    else $error("spurious command while idle");

endmodule

// File: design/lst_dp.sv
// Datapath of the LIN schedule table: slot registers, scan logic and
// result register. Depends on lst_pkg; driven by commands from lst_ctrl.
module lst_dp import lst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_cmd_t   cmd_i,
  output dp_status_t status_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(SLOT_COUNT - 1);

  // Slot table: identifiers reset to empty, payload written before use.
  logic [7:0]  tbl_id_q [SLOT_COUNT];
  slot_pl_t    tbl_pl_q [SLOT_COUNT];

  in_item_t         in_q;
  logic [IDX_W-1:0] next_slot_q, next_slot_d;
  logic [IDX_W-1:0] scan_idx_q, count_q;
  logic             hit_q, empty_q, occ_q;
  logic [IDX_W-1:0] hit_idx_q, empty_idx_q, occ_idx_q;
  logic             out_valid_q;
  out_item_t        out_item_q;

  logic [IDX_W-1:0] tgt_idx, rd_addr;
  logic [7:0]       cur_id;
  slot_pl_t         cur_pl;
  logic             wr_en;
  logic [7:0]       wr_id;
  slot_pl_t         wr_pl;
  out_item_t        res;
  logic [3:0]       size_cl;
  logic             id_match;

  assign size_cl  = clamp_size(in_q.data_size);

  // Slot that the execute step works on.
  always_comb begin
    case (in_q.mode)
      MODE_SET_REQ, MODE_SET_RECV: tgt_idx = hit_q ? hit_idx_q : empty_idx_q;
      MODE_TICK:                   tgt_idx = occ_idx_q;
      default:                     tgt_idx = hit_idx_q;
    endcase
  end

  // Single read port: the scan position while scanning, else the target.
  assign rd_addr  = cmd_i.scan_step ? scan_idx_q : tgt_idx;
  assign cur_id   = tbl_id_q[rd_addr];
  assign cur_pl   = tbl_pl_q[rd_addr];
  assign id_match = (cur_id == in_q.id) && (in_q.id != 8'd0);

  assign status_o.scan_last = (count_q == LastIdx);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Scan registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      empty_q <= 1'b0;
      occ_q   <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q   <= 1'b0;
      empty_q <= 1'b0;
      occ_q   <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (id_match && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (cur_id == 8'd0 && !empty_q) begin
        empty_q <= 1'b1;
      end
      if (cur_id != 8'd0 && !occ_q) begin
        occ_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q       <= in_item_i;
      count_q    <= '0;
      scan_idx_q <= (in_item_i.mode == MODE_TICK) ? next_slot_q : '0;
    end else if (cmd_i.scan_step) begin
      count_q    <= count_q + 1'b1;
      scan_idx_q <= (scan_idx_q == LastIdx) ? '0 : scan_idx_q + 1'b1;
      if (id_match && !hit_q) begin
        hit_idx_q <= scan_idx_q;
      end
      if (cur_id == 8'd0 && !empty_q) begin
        empty_idx_q <= scan_idx_q;
      end
      if (cur_id != 8'd0 && !occ_q) begin
        occ_idx_q <= scan_idx_q;
      end
    end
  end

  // Execute step: table update, schedule pointer and result.
  always_comb begin
    res         = '0;
    wr_en       = 1'b0;
    wr_id       = cur_id;
    wr_pl       = cur_pl;
    next_slot_d = next_slot_q;
    case (in_q.mode)
      MODE_SET_REQ, MODE_SET_RECV: begin
        res.out_id = in_q.id;
        res.found  = hit_q;
        if (in_q.id != 8'd0 && (hit_q || empty_q)) begin
          wr_en       = 1'b1;
          wr_id       = in_q.id;
          wr_pl.size  = size_cl;
          wr_pl.valid = 1'b0;
          if (in_q.mode == MODE_SET_REQ) begin
            wr_pl.data = in_q.data_bytes;
            wr_pl.rx   = 1'b0;
          end else begin
            wr_pl.rx = 1'b1;
            if (!hit_q) begin
              wr_pl.data = '0;
            end
          end
        end
      end
      MODE_REMOVE: begin
        res.out_id = in_q.id;
        res.found  = hit_q;
        if (hit_q) begin
          wr_en = 1'b1;
          wr_id = 8'd0;
          wr_pl = '0;
        end
      end
      MODE_TICK: begin
        if (occ_q) begin
          res.action      = cur_pl.rx ? ACT_RECV_RESP : ACT_SEND_REQ;
          res.out_id      = cur_id;
          res.out_size    = cur_pl.size;
          res.out_data    = cur_pl.data;
          res.is_receiver = cur_pl.rx;
          res.data_valid  = cur_pl.valid;
          res.found       = 1'b1;
          next_slot_d     = (occ_idx_q == LastIdx) ? '0 : occ_idx_q + 1'b1;
        end else begin
          res.action = ACT_NO_SLOTS;
        end
      end
      MODE_FRAME: begin
        if (!in_q.frame_error) begin
          if (hit_q) begin
            wr_en = 1'b1;
            if (cur_pl.rx) begin
              wr_pl.size = size_cl;
              wr_pl.data = in_q.data_bytes;
            end
            wr_pl.valid     = 1'b1;
            res.out_id      = cur_id;
            res.out_size    = wr_pl.size;
            res.out_data    = wr_pl.data;
            res.is_receiver = wr_pl.rx;
            res.data_valid  = 1'b1;
            res.found       = 1'b1;
          end else begin
            res.action = ACT_UNREG_ID;
            res.out_id = in_q.id;
          end
        end
      end
      MODE_QUERY: begin
        res.out_id = in_q.id;
        if (hit_q) begin
          res.out_size    = cur_pl.size;
          res.out_data    = cur_pl.data;
          res.is_receiver = cur_pl.rx;
          res.data_valid  = cur_pl.valid;
          res.found       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Table write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tbl_id_q[i] <= 8'd0;
      end
      next_slot_q <= '0;
    end else if (cmd_i.exec) begin
      if (wr_en) begin
        tbl_id_q[tgt_idx] <= wr_id;
      end
      next_slot_q <= next_slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      tbl_pl_q[tgt_idx] <= wr_pl;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten");

  // The recorded match really holds the requested identifier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && hit_q) |-> (tbl_id_q[hit_idx_q] == in_q.id && in_q.id != 8'd0))
    else $error("stale match index");

  // A reported slot always has an identifier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && res.found) |-> res.out_id != 8'd0)
    else $error("found result names an empty slot");

endmodule

// File: design/lin_schedule_table.sv
// Top level of the LIN master schedule table.
// Depends on lst_pkg and instantiates lst_ctrl and lst_dp.
//
// This block keeps a table of SLOT_COUNT LIN frame slots and answers one
// command per input transfer with exactly one result transfer. Commands set
// a master-request or slave-response slot, remove a slot, ask for the next
// frame to schedule (round-robin over occupied slots, empty ones skipped),
// report a finished frame, or query a slot. Each item goes through an accept
// step, a scan of the table slot by slot through its single read port, and
// an execute step that updates the table and loads the result register; the
// execute step waits while an earlier result is still stalled in the output
// register. Items are handled one at a time; the next item is taken as soon
// as the result of the previous one sits in the output register, even while
// the consumer still stalls it. After reset every slot is empty and the
// round-robin pointer starts at slot zero; there is no clearing pass, so the
// block accepts an item as soon as reset is released.
module lin_schedule_table import lst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // The controller sequences accept, scan and execute.
  lst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the table, the scan results and the result register.
  lst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the LIN schedule table lin_schedule_table.
// Depends on lst_pkg and the design files; it carries its own slot-table
// model and checks every result transfer against it.
module testbench;
  import lst_pkg::*;

  // Run length and pacing.
  localparam int RANDOM_ITEMS = 1930;
  localparam int SEGMENT_LEN  = 150;
  localparam int HOLD_LEN     = 300;
  localparam int DRAIN_CYCLES = 4 * (SLOT_COUNT + 2);
  localparam int CYCLE_LIMIT  = 500000;
  localparam int REPORT_MAX   = 10;

  // Clock, reset and the block's ports. Every input has a known value from
  // time zero on.
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Commands waiting to be offered, and the results still owed by the block.
  in_item_t  commands_to_send [$];
  out_item_t answers_due [$];

  int total_items    = 0;
  int accepted_count = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int hold_cycles    = 0;
  int holds_done     = 0;

  // Our own copy of the slot table and of the round-robin pointer.
  logic [7:0]  slot_id    [SLOT_COUNT] = '{default: '0};
  logic [3:0]  slot_size  [SLOT_COUNT] = '{default: '0};
  logic [63:0] slot_data  [SLOT_COUNT] = '{default: '0};
  logic        slot_rx    [SLOT_COUNT] = '{default: 1'b0};
  logic        slot_valid [SLOT_COUNT] = '{default: 1'b0};
  int          rr_ptr = 0;

  lin_schedule_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // The run is split in three parts by the number of accepted transfers.
  // In the first the sender idles rarely and the receiver often, in the
  // second it is the other way round, and in the last neither idles.
  function automatic int idle_pct(input bit receiver);
    if (accepted_count < total_items / 3) begin
      return receiver ? 55 : 10;
    end else if (accepted_count < (2 * total_items) / 3) begin
      return receiver ? 10 : 55;
    end
    return 0;
  endfunction

  // The reported contents of one slot, with found set and action done.
  function automatic out_item_t slot_report(input int s);
    out_item_t r;
    r             = '0;
    r.out_id      = slot_id[s];
    r.out_size    = slot_size[s];
    r.out_data    = slot_data[s];
    r.is_receiver = slot_rx[s];
    r.data_valid  = slot_valid[s];
    r.found       = 1'b1;
    return r;
  endfunction

  // Applies one accepted command to the slot table copy and returns the
  // result the block owes for it.
  function automatic out_item_t schedule_table_answer(input in_item_t cmd);
    out_item_t  ans;
    logic [3:0] sz;
    int         hit;
    int         free_slot;
    int         slot;
    int         idx;
    int         i;
    ans       = '0;
    sz        = (cmd.data_size > MAX_SIZE) ? MAX_SIZE : cmd.data_size;
    hit       = -1;
    free_slot = -1;
    // Identifier zero marks an empty slot, so it never matches.
    for (i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (cmd.id != 8'd0 && slot_id[i] == cmd.id) hit = i;
      if (slot_id[i] == 8'd0) free_slot = i;
    end
    case (cmd.mode)
      MODE_SET_REQ, MODE_SET_RECV: begin
        ans.out_id = cmd.id;
        slot = -1;
        if (cmd.id != 8'd0) begin
          if (hit >= 0) begin
            slot      = hit;
            ans.found = 1'b1;
          end else if (free_slot >= 0) begin
            // A new slot starts with no data; a full table drops the command.
            slot            = free_slot;
            slot_id[slot]   = cmd.id;
            slot_data[slot] = '0;
          end
        end
        if (slot >= 0) begin
          slot_size[slot]  = sz;
          slot_valid[slot] = 1'b0;
          if (cmd.mode == MODE_SET_REQ) begin
            slot_data[slot] = cmd.data_bytes;
            slot_rx[slot]   = 1'b0;
          end else begin
            slot_rx[slot]   = 1'b1;
          end
        end
      end
      MODE_REMOVE: begin
        ans.out_id = cmd.id;
        if (hit >= 0) begin
          slot_id[hit]    = '0;
          slot_size[hit]  = '0;
          slot_data[hit]  = '0;
          slot_rx[hit]    = 1'b0;
          slot_valid[hit] = 1'b0;
          ans.found       = 1'b1;
        end
      end
      MODE_TICK: begin
        slot = -1;
        for (i = 0; i < SLOT_COUNT; i++) begin
          idx = (rr_ptr + i) % SLOT_COUNT;
          if (slot < 0 && slot_id[idx] != 8'd0) slot = idx;
        end
        if (slot < 0) begin
          ans.action = ACT_NO_SLOTS;
        end else begin
          rr_ptr     = (slot + 1) % SLOT_COUNT;
          ans        = slot_report(slot);
          ans.action = slot_rx[slot] ? ACT_RECV_RESP : ACT_SEND_REQ;
        end
      end
      MODE_FRAME: begin
        if (!cmd.frame_error) begin
          if (hit < 0) begin
            ans.action = ACT_UNREG_ID;
            ans.out_id = cmd.id;
          end else begin
            // Only a receiver slot takes the frame's bytes; any slot is
            // marked as holding fresh data.
            if (slot_rx[hit]) begin
              slot_size[hit] = sz;
              slot_data[hit] = cmd.data_bytes;
            end
            slot_valid[hit] = 1'b1;
            ans             = slot_report(hit);
          end
        end
      end
      MODE_QUERY: begin
        ans.out_id = cmd.id;
        if (hit >= 0) ans = slot_report(hit);
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  // Field by field comparison of one result transfer with its expectation.
  task automatic compare_answer(input out_item_t want, input out_item_t got);
    if (got.action !== want.action || got.out_id !== want.out_id ||
        got.out_size !== want.out_size || got.out_data !== want.out_data ||
        got.is_receiver !== want.is_receiver || got.data_valid !== want.data_valid ||
        got.found !== want.found) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("mismatch at cycle %0d:", cycle_count);
        $display("  expected act %0d id %h size %0d data %h rx %b vld %b fnd %b",
                 want.action, want.out_id, want.out_size, want.out_data,
                 want.is_receiver, want.data_valid, want.found);
        $display("  actual   act %0d id %h size %0d data %h rx %b vld %b fnd %b",
                 got.action, got.out_id, got.out_size, got.out_data,
                 got.is_receiver, got.data_valid, got.found);
      end
    end
  endtask

  task automatic queue_command(input logic [2:0] mode, input logic [7:0] id,
                               input logic [3:0] size, input logic [63:0] bytes,
                               input logic err);
    in_item_t c;
    c.mode        = mode;
    c.id          = id;
    c.data_size   = size;
    c.data_bytes  = bytes;
    c.frame_error = err;
    commands_to_send.push_back(c);
  endtask

  // Driver. A transfer happens at an edge where valid is high and the block
  // does not stall. The expectation is worked out at that edge from the
  // payload that was on the bus. The next command is only put on the bus
  // once the previous one has been taken, so a stalled payload never moves.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin : drive
      logic held;
      held = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        answers_due.push_back(schedule_table_answer(in_item_i));
        accepted_count <= accepted_count + 1;
        held = 1'b0;
      end
      if (!held) begin
        if (commands_to_send.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          in_item_i  <= commands_to_send.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall. Twice in the run the receiver holds off for a long
  // stretch while the sender keeps offering commands, so the output
  // register stays full and the block has to stall its input side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if ((holds_done == 0 && accepted_count >= total_items / 6) ||
                 (holds_done == 1 && accepted_count >= total_items / 2)) begin
      holds_done  <= holds_done + 1;
      hold_cycles <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < idle_pct(1'b1));
    end
  end

  // Monitor. Every result transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected result transfer at cycle %0d: act %0d id %h",
                   cycle_count, out_item_o.action, out_item_o.out_id);
        end
      end else begin
        compare_answer(answers_due.pop_front(), out_item_o);
      end
    end
  end

  // Stimulus and end of the run.
  initial begin : stimulus
    logic [7:0] id_pool [64];
    int         pool_len;
    int         remove_weight;
    int         r;
    int         n;
    int         k;
    logic [2:0] mode;
    logic [7:0] id;
    logic [3:0] size;

    // Directed commands: the empty table, identifier zero, saturated sizes,
    // receiver and request slots, frames with and without error, wrap of
    // the round-robin pointer, skipping an empty slot and the unused modes.
    queue_command(MODE_TICK,     8'h00, 4'd0,  64'h0, 1'b0);
    queue_command(MODE_QUERY,    8'h00, 4'd0,  64'h0, 1'b0);
    queue_command(MODE_SET_REQ,  8'h00, 4'd4,  64'hDEAD_BEEF_0000_1111, 1'b0);
    queue_command(MODE_REMOVE,   8'h00, 4'd0,  64'h0, 1'b0);
    queue_command(MODE_FRAME,    8'h00, 4'd2,  64'h55, 1'b0);
    queue_command(MODE_SET_REQ,  8'hFF, 4'hF,  '1,    1'b1);
    queue_command(MODE_SET_RECV, 8'h01, 4'd0,  '1,    1'b0);
    queue_command(MODE_SET_RECV, 8'hFF, 4'd9,  64'h0, 1'b0);
    queue_command(MODE_FRAME,    8'h01, 4'd8,  '1,    1'b1);
    queue_command(MODE_FRAME,    8'h01, 4'hC,  64'h0123_4567_89AB_CDEF, 1'b0);
    queue_command(MODE_SET_REQ,  8'h80, 4'd3,  64'hA5A5_5A5A_F0F0_0F0F, 1'b0);
    queue_command(MODE_FRAME,    8'h80, 4'd5,  64'h1234, 1'b0);
    queue_command(MODE_FRAME,    8'h7E, 4'd1,  64'h1, 1'b0);
    for (k = 0; k < 4; k++) begin
      queue_command(MODE_TICK, 8'h00, 4'd0, 64'h0, 1'b0);
    end
    queue_command(MODE_QUERY,    8'hFF, 4'd0,  64'h0, 1'b0);
    queue_command(MODE_REMOVE,   8'hFF, 4'd0,  64'h0, 1'b0);
    queue_command(MODE_REMOVE,   8'hFF, 4'd0,  64'h0, 1'b0);
    queue_command(MODE_TICK,     8'h00, 4'd0,  64'h0, 1'b0);
    queue_command(3'd6,          8'h42, 4'd7,  '1,    1'b1);
    queue_command(3'd7,          8'hBD, 4'hF,  64'h8000_0000_0000_0001, 1'b0);

    // Random commands in segments. Each segment works on its own small pool
    // of identifiers, so slots are hit again and again and the table often
    // fills up; the weight of removals changes so it also drains at times.
    pool_len      = 1;
    remove_weight = 10;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        case ($urandom_range(0, 3))
          0: pool_len = 3;
          1: pool_len = 12;
          2: pool_len = 24;
          default: pool_len = 64;
        endcase
        for (k = 0; k < pool_len; k++) id_pool[k] = 8'($urandom_range(1, 255));
        remove_weight = $urandom_range(3, 40);
      end
      r = $urandom_range(0, 85 + remove_weight);
      if (r < 24)                       mode = MODE_SET_REQ;
      else if (r < 42)                  mode = MODE_SET_RECV;
      else if (r < 58)                  mode = MODE_TICK;
      else if (r < 74)                  mode = MODE_FRAME;
      else if (r < 84)                  mode = MODE_QUERY;
      else if (r < 86)                  mode = 3'($urandom_range(6, 7));
      else                              mode = MODE_REMOVE;
      id   = ($urandom_range(0, 99) < 3) ? 8'h00 : id_pool[$urandom_range(0, pool_len - 1)];
      size = ($urandom_range(0, 99) < 15) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
      queue_command(mode, id, size, {$urandom, $urandom}, ($urandom_range(0, 99) < 20));
    end
    total_items = commands_to_send.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every command to be taken and every result to come back,
    // then give the block time to show any stray result.
    while (commands_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    mismatches += answers_due.size();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop for a hung block.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
